>>> design/circular_double_ended_queue_core_assert.svh
// Assertion macros for the circular double-ended queue core.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTH
`define CDQ_ASSERT_SAME(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("cdq assertion failed in the same cycle");
`define CDQ_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("cdq assertion failed in the next cycle");
`else
`define CDQ_ASSERT_SAME(label, clock, rstn, ante, cons)
`define CDQ_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif

`endif

>>> design/cdq_pkg.sv
// Shared types and codes of the circular double-ended queue core.
`default_nettype none
package cdq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_READ       = 3'd4,
		REQ_CLEAR      = 3'd5,
		REQ_SET_LEN    = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_INDEX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE       = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_PUSH_FRONT = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_POP_FRONT  = 3'd4,
		OP_READ       = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    load_req;
		logic    load_out;
		logic    set_status;
		status_t status;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic pos_oob;
		logic len_big;
		logic len_gt;
		logic len_lt;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

>>> design/cdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule
`default_nettype wire

>>> design/cdq_ctrl.sv
// Controller state machine that sequences each request of the queue.
`default_nettype none
module cdq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cdq_pkg::sts_t sts,
	output cdq_pkg::cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SIZE = 5'b00100,
		S_LOOK = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd.op         = cdq_pkg::OP_NONE;
		cmd.load_req   = 1'b0;
		cmd.load_out   = 1'b0;
		cmd.set_status = 1'b0;
		cmd.status     = cdq_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_LOOK;
				case (sts.req)
					cdq_pkg::REQ_PUSH_BACK, cdq_pkg::REQ_PUSH_FRONT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = cdq_pkg::ST_FULL;
						end else if (sts.req == cdq_pkg::REQ_PUSH_BACK) begin
							cmd.op = cdq_pkg::OP_PUSH_BACK;
						end else begin
							cmd.op = cdq_pkg::OP_PUSH_FRONT;
						end
					end
					cdq_pkg::REQ_POP_BACK, cdq_pkg::REQ_POP_FRONT: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = cdq_pkg::ST_EMPTY;
						end else if (sts.req == cdq_pkg::REQ_POP_BACK) begin
							cmd.op = cdq_pkg::OP_POP_BACK;
						end else begin
							cmd.op = cdq_pkg::OP_POP_FRONT;
						end
					end
					cdq_pkg::REQ_READ: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = cdq_pkg::ST_EMPTY;
						end else if (sts.pos_oob) begin
							cmd.set_status = 1'b1;
							cmd.status     = cdq_pkg::ST_INDEX;
						end else begin
							cmd.op = cdq_pkg::OP_READ;
						end
					end
					cdq_pkg::REQ_CLEAR: begin
						cmd.op = cdq_pkg::OP_CLEAR;
					end
					cdq_pkg::REQ_SET_LEN: begin
						if (sts.len_big) begin
							cmd.set_status = 1'b1;
							cmd.status     = cdq_pkg::ST_FULL;
						end else begin
							state_d = S_SIZE;
						end
					end
					default: begin
					end
				endcase
			end
			S_SIZE: begin
				if (sts.len_gt) begin
					cmd.op = cdq_pkg::OP_POP_BACK;
				end else if (sts.len_lt) begin
					cmd.op = cdq_pkg::OP_PUSH_BACK;
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/cdq_dpath.sv
// Datapath of the queue: pointers, element store and result register.
`default_nettype none
module cdq_dpath #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cdq_pkg::cmd_t         cmd,
	output cdq_pkg::sts_t              sts,
	input  wire logic [2:0]            req_type,
	input  wire logic [DATA_WIDTH-1:0] item_value,
	input  wire logic [AW-1:0]         position,
	input  wire logic [CW-1:0]         new_length,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [DATA_WIDTH-1:0]      read_data,
	output logic [DATA_WIDTH-1:0]      front_value,
	output logic [DATA_WIDTH-1:0]      back_value,
	output logic [CW-1:0]              count,
	output logic                       is_empty,
	output cdq_pkg::status_t           status
);

	localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	cdq_pkg::req_t    req_q;
	cdq_pkg::status_t status_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         len_q;

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rd_pend_q;
	logic          out_valid_q;

	logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [AW:0]   idx_sum;
	logic [AW-1:0] idx;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr_a;
	logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;

	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - 1'b1;

	assign idx_sum = {1'b0, head_q} + {1'b0, pos_q};
	always_comb begin
		logic [AW:0] wrapped;
		wrapped = (idx_sum >= CAP_W) ? idx_sum - CAP_W : idx_sum;
		idx     = wrapped[AW-1:0];
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		cnt_d   = cnt_q;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		case (cmd.op)
			cdq_pkg::OP_PUSH_BACK: begin
				wr_en = 1'b1;
				if (cnt_q == '0) begin
					head_d = '0;
					tail_d = '0;
				end else begin
					tail_d = tail_inc;
				end
				wr_addr = tail_d;
				cnt_d   = cnt_q + 1'b1;
			end
			cdq_pkg::OP_PUSH_FRONT: begin
				wr_en = 1'b1;
				if (cnt_q == '0) begin
					head_d = LAST;
					tail_d = LAST;
				end else begin
					head_d = head_dec;
				end
				wr_addr = head_d;
				cnt_d   = cnt_q + 1'b1;
			end
			cdq_pkg::OP_POP_BACK: begin
				if (cnt_q == CW'(1)) begin
					head_d = '0;
					tail_d = '0;
				end else begin
					tail_d = tail_dec;
				end
				cnt_d = cnt_q - 1'b1;
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (cnt_q == CW'(1)) begin
					head_d = '0;
					tail_d = '0;
				end else begin
					head_d = head_inc;
				end
				cnt_d = cnt_q - 1'b1;
			end
			cdq_pkg::OP_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				cnt_d  = '0;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr_a = (cmd.op == cdq_pkg::OP_READ) ? idx : head_q;

	cdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (val_q),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_addr_b (tail_q),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			cnt_q     <= cnt_d;
			rd_pend_q <= (cmd.op == cdq_pkg::OP_READ);
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q    <= cdq_pkg::req_t'(req_type);
			val_q    <= item_value;
			pos_q    <= position;
			len_q    <= new_length;
			rd_q     <= '0;
			status_q <= cdq_pkg::ST_OK;
		end else begin
			if (rd_pend_q) begin
				rd_q <= rd_data_a;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
		end
		if (cmd.load_out) begin
			read_data   <= rd_q;
			front_value <= (cnt_q == '0) ? '0 : rd_data_a;
			back_value  <= (cnt_q == '0) ? '0 : rd_data_b;
			count       <= cnt_q;
			is_empty    <= (cnt_q == '0);
			status      <= status_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.req      = req_q;
	assign sts.full     = (cnt_q == CAP_C);
	assign sts.empty    = (cnt_q == '0);
	assign sts.pos_oob  = (CW'(pos_q) >= cnt_q);
	assign sts.len_big  = (len_q > CAP_C);
	assign sts.len_gt   = (cnt_q > len_q);
	assign sts.len_lt   = (cnt_q < len_q);
	assign sts.out_busy = out_valid_q & ~out_ready;

endmodule
`default_nettype wire

>>> design/circular_double_ended_queue_core.sv
// Top level of the circular double-ended queue core.
//
// Requests arrive on the s_axis channel, one transaction per request, with the
// request code in s_axis_tuser. Each request gives exactly one result
// transaction on the m_axis channel, carrying the read data, the front and
// back elements, the count and the empty flag, with the status in m_axis_tuser.
// The block handles one request at a time. Push, pop, read, clear and an
// unused code pass through the execute, look and response states after
// acceptance before loading the result register, and the next request can be
// taken in the cycle after that. A set-length request passes through a resize
// state that drops or adds elements at the back until the count matches the
// new length; the store has one write port, so fills write one entry per cycle.
// The next request is accepted as soon as the previous result has been loaded,
// even while it still waits to be taken. If the receiver stalls, the result
// holds and a further finished result waits until the register frees.
// Reset empties the queue and drops any pending result; stored elements are
// left as they were and are never read before being written again.
`default_nettype none
module circular_double_ended_queue_core #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int IN_TW   = ((DATA_WIDTH + AW + CW + 7) / 8) * 8,
	localparam int OUT_TW  = ((3 * DATA_WIDTH + CW + 1 + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0: item_value, position, new_length, zero padding.
	input  wire logic [IN_TW-1:0]  s_axis_tdata,
	// Fields from bit 0: req_type.
	input  wire logic [2:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// Fields from bit 0: read_data, front_value, back_value, count, is_empty, padding.
	output logic [OUT_TW-1:0]      m_axis_tdata,
	// Fields from bit 0: status.
	output logic [1:0]             m_axis_tuser
);

	`include "circular_double_ended_queue_core_assert.svh"

	cdq_pkg::cmd_t    cmd;
	cdq_pkg::sts_t    sts;
	cdq_pkg::status_t status;

	logic [DATA_WIDTH-1:0] read_data, front_value, back_value;
	logic [CW-1:0]         count;
	logic                  is_empty;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdq_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (s_axis_tuser),
		.item_value  (s_axis_tdata[DATA_WIDTH-1:0]),
		.position    (s_axis_tdata[DATA_WIDTH +: AW]),
		.new_length  (s_axis_tdata[DATA_WIDTH + AW +: CW]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.read_data   (read_data),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status)
	);

	assign m_axis_tdata = OUT_TW'({is_empty, count, back_value, front_value, read_data});
	assign m_axis_tuser = status;

	`CDQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`CDQ_ASSERT_SAME(a_empty_ends_zero, clk, arst_n, m_axis_tvalid && is_empty, front_value == '0 && back_value == '0)
	`CDQ_ASSERT_SAME(a_error_no_data, clk, arst_n, m_axis_tvalid && status != cdq_pkg::ST_OK, read_data == '0)
	`CDQ_ASSERT_SAME(a_count_bound, clk, arst_n, m_axis_tvalid, count <= CW'(CAPACITY) && is_empty == (count == '0))

endmodule
`default_nettype wire
